// File: rtl/core/mpnb_pkg.sv
// Shared types and constants for the Manhattan path normalize / bounding box block.
`default_nettype none

package mpnb_pkg;

  // Box arithmetic runs in 33 bits; doubled offsets need one more bit
  localparam int BOX_W  = 33;
  localparam int EXT_W  = BOX_W + 1;
  localparam int WABS_W = 32;
  localparam int CNT_W  = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATH_WIDTH = 2'd0,
    CFG_END_STYLE  = 2'd1
  } cfg_idx_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIAG  = 2'd1,
    ST_SHORT = 2'd2
  } status_t;

  // Slots of the coordinate bundle handed from tracker to box unit
  localparam int P_BLX = 0;   // point box low x
  localparam int P_BLY = 1;
  localparam int P_BHX = 2;
  localparam int P_BHY = 3;
  localparam int P_VLO = 4;   // x extent of vertical segments
  localparam int P_VHI = 5;
  localparam int P_HLO = 6;   // y extent of horizontal segments
  localparam int P_HHI = 7;
  localparam int P_FX  = 8;   // first point
  localparam int P_FY  = 9;
  localparam int P_T0X = 10;  // last two normalized points
  localparam int P_T0Y = 11;
  localparam int P_T1X = 12;
  localparam int P_T1Y = 13;
  localparam int NPT   = 14;

  // Per-path flags captured with the final vertex
  typedef struct packed {
    status_t status;
    logic    has_v;
    logic    has_h;
    logic    first_vert;
    logic    first_inc;
  } mpnb_flags_t;

endpackage

`default_nettype wire

// File: rtl/core/manhattan_path_normalize_bbox.sv
// Top level: configuration registers and the tracker / box pipeline.
//
// Takes one path vertex per cycle through a valid/ready input, except that a
// final vertex waits while the snapshot register is full; the limit is the
// path-state update on the input register, which closes its loop per vertex.
// Only the vertex marked final produces a result word: status, bounding box
// and normalized vertex count reach the output register once the word has
// moved from the input register through the snapshot and offset candidate
// registers into the min/max result register. Vertices of the next path are
// accepted while a result waits. Width and end style must be written
// through the cfg port while the block is idle; the block itself does not
// enforce this. Negative widths behave as their absolute value. Coordinates
// use the low COORD_BITS bits of each input, sign extended.
`default_nettype none

module manhattan_path_normalize_bbox import mpnb_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]             cfg_data,
  // vertex input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [31:0]      in_vertex_x,
  input  logic signed [31:0]      in_vertex_y,
  input  logic                    in_final_vertex,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic signed [BOX_W-1:0] out_box_low_x,
  output logic signed [BOX_W-1:0] out_box_low_y,
  output logic signed [BOX_W-1:0] out_box_high_x,
  output logic signed [BOX_W-1:0] out_box_high_y,
  output logic [CNT_W-1:0]        out_vertex_count
);

  logic [WABS_W-1:0] w_abs_r, w_abs_nxt;
  logic [WABS_W-1:0] w_m1_r;
  logic [WABS_W:0]   w_p1_r;
  logic              w_zero_r;
  logic [2:0]        end_style_r;

  logic                           snap_valid, snap_ready;
  mpnb_flags_t                    snap_flags;
  logic [CNT_W-1:0]               snap_count;
  logic [NPT-1:0][COORD_BITS-1:0] snap_pts;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;
  assign w_abs_nxt = cfg_data[31] ? WABS_W'(-cfg_data) : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_abs_r     <= '0;
      end_style_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PATH_WIDTH: w_abs_r     <= w_abs_nxt;
        CFG_END_STYLE:  end_style_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Width terms for the rounding paths, settled well before any result uses them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r   <= '1;
      w_p1_r   <= (WABS_W+1)'(1);
      w_zero_r <= 1'b1;
    end else begin
      w_m1_r   <= w_abs_r - WABS_W'(1);
      w_p1_r   <= (WABS_W+1)'(w_abs_r) + (WABS_W+1)'(1);
      w_zero_r <= (w_abs_r == '0);
    end
  end

  mpnb_track #(
    .CB (COORD_BITS)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_x       ($signed(in_vertex_x[COORD_BITS-1:0])),
    .in_y       ($signed(in_vertex_y[COORD_BITS-1:0])),
    .in_last    (in_final_vertex),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_flags (snap_flags),
    .snap_count (snap_count),
    .snap_pts   (snap_pts)
  );

  mpnb_box #(
    .CB (COORD_BITS)
  ) u_box (
    .clk              (clk),
    .rst_n            (rst_n),
    .snap_valid       (snap_valid),
    .snap_ready       (snap_ready),
    .snap_flags       (snap_flags),
    .snap_count       (snap_count),
    .snap_pts         (snap_pts),
    .w_abs            (w_abs_r),
    .w_m1             (w_m1_r),
    .w_p1             (w_p1_r),
    .w_zero           (w_zero_r),
    .end_on           (end_style_r != '0),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_box_low_x    (out_box_low_x),
    .out_box_low_y    (out_box_low_y),
    .out_box_high_x   (out_box_high_x),
    .out_box_high_y   (out_box_high_y),
    .out_vertex_count (out_vertex_count)
  );

endmodule

`default_nettype wire

// File: rtl/core/mpnb_track.sv
// Path tracker: normalizes incoming vertices and keeps the running path state.
`default_nettype none

module mpnb_track import mpnb_pkg::*; #(
  parameter int CB = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [CB-1:0]   in_x,
  input  logic signed [CB-1:0]   in_y,
  input  logic                   in_last,
  output logic                   snap_valid,
  input  logic                   snap_ready,
  output mpnb_flags_t            snap_flags,
  output logic [CNT_W-1:0]       snap_count,
  output logic [NPT-1:0][CB-1:0] snap_pts
);

  // Input word register
  logic                 a_valid_r;
  logic                 a_last_r;
  logic signed [CB-1:0] a_x_r, a_y_r;
  logic                 a_go;
  logic                 s_free;

  // Path state
  logic                 have_rp_r, have_rp_nxt;
  logic                 diag_r, diag_nxt;
  logic                 has_v_r, has_v_nxt;
  logic                 has_h_r, has_h_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic signed [CB-1:0] rp_x_r, rp_x_nxt, rp_y_r, rp_y_nxt;
  logic signed [CB-1:0] t0x_r, t0x_nxt, t0y_r, t0y_nxt;
  logic signed [CB-1:0] t1x_r, t1x_nxt, t1y_r, t1y_nxt;
  logic signed [CB-1:0] fx_r, fx_nxt, fy_r, fy_nxt;
  logic                 fvert_r, fvert_nxt, finc_r, finc_nxt;
  logic signed [CB-1:0] blx_r, blx_nxt, bly_r, bly_nxt;
  logic signed [CB-1:0] bhx_r, bhx_nxt, bhy_r, bhy_nxt;
  logic signed [CB-1:0] vlo_r, vlo_nxt, vhi_r, vhi_nxt;
  logic signed [CB-1:0] hlo_r, hlo_nxt, hhi_r, hhi_nxt;

  // Snapshot register
  logic                   snap_valid_r;
  mpnb_flags_t            snap_flags_r, snap_flags_nxt;
  logic [CNT_W-1:0]       snap_count_r, snap_count_nxt;
  logic [NPT-1:0][CB-1:0] snap_pts_r, snap_pts_nxt;

  logic dup, same_x, vcol, hcol, vok, hok, merge;

  // Handshake: a final vertex needs a free snapshot slot
  assign s_free   = !snap_valid_r || snap_ready;
  assign a_go     = a_valid_r && (!a_last_r || s_free);
  assign in_ready = !a_valid_r || a_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_x_r    <= in_x;
      a_y_r    <= in_y;
      a_last_r <= in_last;
    end
  end

  // Point classification against the tail
  assign dup    = (cnt_r != '0) && (a_x_r == t1x_r) && (a_y_r == t1y_r);
  assign same_x = (a_x_r == t1x_r);
  assign vcol   = same_x && (a_x_r == t0x_r);
  assign hcol   = (a_y_r == t1y_r) && (a_y_r == t0y_r);
  assign vok    = !(((a_y_r > t1y_r) && (t1y_r < t0y_r)) ||
                    ((a_y_r < t1y_r) && (t1y_r > t0y_r)));
  assign hok    = !(((a_x_r > t1x_r) && (t1x_r < t0x_r)) ||
                    ((a_x_r < t1x_r) && (t1x_r > t0x_r)));
  assign merge  = (cnt_r >= CNT_W'(2)) && (vcol ? vok : (hcol && hok));

  // Next path state for the word in the input register
  always_comb begin
    have_rp_nxt = 1'b1;
    rp_x_nxt    = a_x_r;
    rp_y_nxt    = a_y_r;
    diag_nxt    = diag_r | (have_rp_r && (a_x_r != rp_x_r) && (a_y_r != rp_y_r));
    has_v_nxt   = has_v_r;
    has_h_nxt   = has_h_r;
    cnt_nxt     = cnt_r;
    t0x_nxt     = t0x_r;
    t0y_nxt     = t0y_r;
    t1x_nxt     = t1x_r;
    t1y_nxt     = t1y_r;
    fx_nxt      = fx_r;
    fy_nxt      = fy_r;
    fvert_nxt   = fvert_r;
    finc_nxt    = finc_r;
    blx_nxt     = blx_r;
    bly_nxt     = bly_r;
    bhx_nxt     = bhx_r;
    bhy_nxt     = bhy_r;
    vlo_nxt     = vlo_r;
    vhi_nxt     = vhi_r;
    hlo_nxt     = hlo_r;
    hhi_nxt     = hhi_r;
    if (!dup) begin
      if (cnt_r == '0) begin
        blx_nxt = a_x_r;
        bhx_nxt = a_x_r;
        bly_nxt = a_y_r;
        bhy_nxt = a_y_r;
      end else begin
        if (a_x_r < blx_r) blx_nxt = a_x_r;
        if (a_y_r < bly_r) bly_nxt = a_y_r;
        if (a_x_r > bhx_r) bhx_nxt = a_x_r;
        if (a_y_r > bhy_r) bhy_nxt = a_y_r;
        // segment extents per orientation
        if (same_x) begin
          if (!has_v_r || (a_x_r < vlo_r)) vlo_nxt = a_x_r;
          if (!has_v_r || (a_x_r > vhi_r)) vhi_nxt = a_x_r;
          has_v_nxt = 1'b1;
        end else begin
          if (!has_h_r || (a_y_r < hlo_r)) hlo_nxt = a_y_r;
          if (!has_h_r || (a_y_r > hhi_r)) hhi_nxt = a_y_r;
          has_h_nxt = 1'b1;
        end
        // first segment fixes the start point and its direction
        if (cnt_r == CNT_W'(1)) begin
          fx_nxt    = t1x_r;
          fy_nxt    = t1y_r;
          fvert_nxt = same_x;
          finc_nxt  = same_x ? (t1y_r < a_y_r) : (t1x_r < a_x_r);
        end
      end
      if (merge) begin
        t1x_nxt = a_x_r;
        t1y_nxt = a_y_r;
      end else begin
        t0x_nxt = t1x_r;
        t0y_nxt = t1y_r;
        t1x_nxt = a_x_r;
        t1y_nxt = a_y_r;
        if (cnt_r != CNT_MAX) cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  // Control state: cleared after every final vertex
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_rp_r <= 1'b0;
      diag_r    <= 1'b0;
      has_v_r   <= 1'b0;
      has_h_r   <= 1'b0;
      cnt_r     <= '0;
    end else if (a_go) begin
      if (a_last_r) begin
        have_rp_r <= 1'b0;
        diag_r    <= 1'b0;
        has_v_r   <= 1'b0;
        has_h_r   <= 1'b0;
        cnt_r     <= '0;
      end else begin
        have_rp_r <= have_rp_nxt;
        diag_r    <= diag_nxt;
        has_v_r   <= has_v_nxt;
        has_h_r   <= has_h_nxt;
        cnt_r     <= cnt_nxt;
      end
    end
  end

  // Coordinate state: only read under the flags above
  always_ff @(posedge clk) begin
    if (a_go) begin
      rp_x_r  <= rp_x_nxt;
      rp_y_r  <= rp_y_nxt;
      t0x_r   <= t0x_nxt;
      t0y_r   <= t0y_nxt;
      t1x_r   <= t1x_nxt;
      t1y_r   <= t1y_nxt;
      fx_r    <= fx_nxt;
      fy_r    <= fy_nxt;
      fvert_r <= fvert_nxt;
      finc_r  <= finc_nxt;
      blx_r   <= blx_nxt;
      bly_r   <= bly_nxt;
      bhx_r   <= bhx_nxt;
      bhy_r   <= bhy_nxt;
      vlo_r   <= vlo_nxt;
      vhi_r   <= vhi_nxt;
      hlo_r   <= hlo_nxt;
      hhi_r   <= hhi_nxt;
    end
  end

  // Snapshot of the finished path
  always_comb begin
    snap_flags_nxt.has_v      = has_v_nxt;
    snap_flags_nxt.has_h      = has_h_nxt;
    snap_flags_nxt.first_vert = fvert_nxt;
    snap_flags_nxt.first_inc  = finc_nxt;
    if (diag_nxt) begin
      snap_flags_nxt.status = ST_DIAG;
    end else if (cnt_nxt < CNT_W'(2)) begin
      snap_flags_nxt.status = ST_SHORT;
    end else begin
      snap_flags_nxt.status = ST_OK;
    end
    snap_count_nxt      = diag_nxt ? '0 : cnt_nxt;
    snap_pts_nxt[P_BLX] = blx_nxt;
    snap_pts_nxt[P_BLY] = bly_nxt;
    snap_pts_nxt[P_BHX] = bhx_nxt;
    snap_pts_nxt[P_BHY] = bhy_nxt;
    snap_pts_nxt[P_VLO] = vlo_nxt;
    snap_pts_nxt[P_VHI] = vhi_nxt;
    snap_pts_nxt[P_HLO] = hlo_nxt;
    snap_pts_nxt[P_HHI] = hhi_nxt;
    snap_pts_nxt[P_FX]  = fx_nxt;
    snap_pts_nxt[P_FY]  = fy_nxt;
    snap_pts_nxt[P_T0X] = t0x_nxt;
    snap_pts_nxt[P_T0Y] = t0y_nxt;
    snap_pts_nxt[P_T1X] = t1x_nxt;
    snap_pts_nxt[P_T1Y] = t1y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (a_go && a_last_r) begin
      snap_valid_r <= 1'b1;
    end else if (snap_ready) begin
      snap_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && a_last_r) begin
      snap_flags_r <= snap_flags_nxt;
      snap_count_r <= snap_count_nxt;
      snap_pts_r   <= snap_pts_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap_flags = snap_flags_r;
  assign snap_count = snap_count_r;
  assign snap_pts   = snap_pts_r;

  // A path with no raw vertex has no normalized points either
  a_empty_path: assert property (@(posedge clk) disable iff (!rst_n)
    !have_rp_r |-> (cnt_r == '0) && !diag_r)
    else $error("normalized points without a raw vertex");

  // The last two normalized points are always distinct
  a_tail_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r >= CNT_W'(2)) |-> ((t0x_r != t1x_r) || (t0y_r != t1y_r)))
    else $error("tail points coincide");

  // A final vertex leaves a cleared path behind
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (a_go && a_last_r) |=> (cnt_r == '0) && !have_rp_r && !has_v_r && !has_h_r)
    else $error("path state not cleared after final vertex");

endmodule

`default_nettype wire

// File: rtl/core/mpnb_box.sv
// Box unit: applies half-width offsets to a finished path and holds the result word.
`default_nettype none

module mpnb_box import mpnb_pkg::*; #(
  parameter int CB = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      snap_valid,
  output logic                      snap_ready,
  input  mpnb_flags_t               snap_flags,
  input  logic [CNT_W-1:0]          snap_count,
  input  logic [NPT-1:0][CB-1:0]    snap_pts,
  input  logic [WABS_W-1:0]         w_abs,
  input  logic [WABS_W-1:0]         w_m1,
  input  logic [WABS_W:0]           w_p1,
  input  logic                      w_zero,
  input  logic                      end_on,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic signed [BOX_W-1:0]   out_box_low_x,
  output logic signed [BOX_W-1:0]   out_box_low_y,
  output logic signed [BOX_W-1:0]   out_box_high_x,
  output logic signed [BOX_W-1:0]   out_box_high_y,
  output logic [CNT_W-1:0]          out_vertex_count
);

  // Sides of the box and candidate slots per side
  localparam int S_LX = 0;
  localparam int S_LY = 1;
  localparam int S_HX = 2;
  localparam int S_HY = 3;
  localparam int NSIDE = 4;
  localparam int NCAND = 4;

  // (2v - w) / 2 truncated toward zero; s + 1 is precomputed through w - 1
  function automatic logic signed [BOX_W-1:0] lo_off(
    input logic signed [CB-1:0] v,
    input logic [WABS_W-1:0]    w,
    input logic [WABS_W-1:0]    wm1
  );
    logic signed [EXT_W-1:0] v2, s, s1;
    v2 = EXT_W'(v) <<< 1;
    s  = v2 - $signed(EXT_W'(w));
    s1 = v2 - $signed(EXT_W'(wm1));
    lo_off = s[EXT_W-1] ? s1[EXT_W-1:1] : s[EXT_W-1:1];
  endfunction

  // (2v + w) / 2 truncated toward zero
  function automatic logic signed [BOX_W-1:0] hi_off(
    input logic signed [CB-1:0] v,
    input logic [WABS_W-1:0]    w,
    input logic [WABS_W:0]      wp1
  );
    logic signed [EXT_W-1:0] v2, t, t1;
    v2 = EXT_W'(v) <<< 1;
    t  = v2 + $signed(EXT_W'(w));
    t1 = v2 + $signed(EXT_W'(wp1));
    hi_off = t[EXT_W-1] ? t1[EXT_W-1:1] : t[EXT_W-1:1];
  endfunction

  function automatic logic signed [BOX_W-1:0] min2(
    input logic signed [BOX_W-1:0] a,
    input logic signed [BOX_W-1:0] b
  );
    min2 = (a < b) ? a : b;
  endfunction

  function automatic logic signed [BOX_W-1:0] max2(
    input logic signed [BOX_W-1:0] a,
    input logic signed [BOX_W-1:0] b
  );
    max2 = (a > b) ? a : b;
  endfunction

  logic signed [CB-1:0] p_blx, p_bly, p_bhx, p_bhy, p_vlo, p_vhi, p_hlo, p_hhi;
  logic signed [CB-1:0] p_fx, p_fy, p_t0x, p_t0y, p_t1x, p_t1y;
  logic                 tvert, tdec;
  logic                 e_fx_lo, e_fx_hi, e_fy_lo, e_fy_hi;
  logic                 e_tx_lo, e_tx_hi, e_ty_lo, e_ty_hi;

  // Candidate stage
  logic                                     t_valid_r;
  logic [NSIDE-1:0][NCAND-1:0][BOX_W-1:0]   t_cand_r, t_cand_nxt;
  status_t                                  t_status_r;
  logic [CNT_W-1:0]                         t_count_r;
  logic                                     t_zero_r;
  logic                                     out_free;

  // Result word register
  logic                          out_valid_r;
  status_t                       out_status_r;
  logic signed [BOX_W-1:0]       out_blx_r, out_bly_r, out_bhx_r, out_bhy_r;
  logic signed [BOX_W-1:0]       out_blx_nxt, out_bly_nxt, out_bhx_nxt, out_bhy_nxt;
  logic [CNT_W-1:0]              out_count_r;

  assign out_free   = !out_valid_r || out_ready;
  assign snap_ready = !t_valid_r || out_free;

  assign p_blx = $signed(snap_pts[P_BLX]);
  assign p_bly = $signed(snap_pts[P_BLY]);
  assign p_bhx = $signed(snap_pts[P_BHX]);
  assign p_bhy = $signed(snap_pts[P_BHY]);
  assign p_vlo = $signed(snap_pts[P_VLO]);
  assign p_vhi = $signed(snap_pts[P_VHI]);
  assign p_hlo = $signed(snap_pts[P_HLO]);
  assign p_hhi = $signed(snap_pts[P_HHI]);
  assign p_fx  = $signed(snap_pts[P_FX]);
  assign p_fy  = $signed(snap_pts[P_FY]);
  assign p_t0x = $signed(snap_pts[P_T0X]);
  assign p_t0y = $signed(snap_pts[P_T0Y]);
  assign p_t1x = $signed(snap_pts[P_T1X]);
  assign p_t1y = $signed(snap_pts[P_T1Y]);

  // End extensions: start end pushes against the first step, tail end along the last
  assign tvert   = (p_t0x == p_t1x);
  assign tdec    = tvert ? (p_t1y < p_t0y) : (p_t1x < p_t0x);
  assign e_fx_lo = end_on && !snap_flags.first_vert &&  snap_flags.first_inc;
  assign e_fx_hi = end_on && !snap_flags.first_vert && !snap_flags.first_inc;
  assign e_fy_lo = end_on &&  snap_flags.first_vert &&  snap_flags.first_inc;
  assign e_fy_hi = end_on &&  snap_flags.first_vert && !snap_flags.first_inc;
  assign e_tx_lo = end_on && !tvert &&  tdec;
  assign e_tx_hi = end_on && !tvert && !tdec;
  assign e_ty_lo = end_on &&  tvert &&  tdec;
  assign e_ty_hi = end_on &&  tvert && !tdec;

  // Each side gets the point extent plus up to three offset candidates;
  // an unused candidate repeats the point extent
  always_comb begin
    t_cand_nxt[S_LX][0] = BOX_W'(p_blx);
    t_cand_nxt[S_LX][1] = snap_flags.has_v ? lo_off(p_vlo, w_abs, w_m1) : BOX_W'(p_blx);
    t_cand_nxt[S_LX][2] = e_fx_lo ? lo_off(p_fx, w_abs, w_m1) : BOX_W'(p_blx);
    t_cand_nxt[S_LX][3] = e_tx_lo ? lo_off(p_t1x, w_abs, w_m1) : BOX_W'(p_blx);

    t_cand_nxt[S_LY][0] = BOX_W'(p_bly);
    t_cand_nxt[S_LY][1] = snap_flags.has_h ? lo_off(p_hlo, w_abs, w_m1) : BOX_W'(p_bly);
    t_cand_nxt[S_LY][2] = e_fy_lo ? lo_off(p_fy, w_abs, w_m1) : BOX_W'(p_bly);
    t_cand_nxt[S_LY][3] = e_ty_lo ? lo_off(p_t1y, w_abs, w_m1) : BOX_W'(p_bly);

    t_cand_nxt[S_HX][0] = BOX_W'(p_bhx);
    t_cand_nxt[S_HX][1] = snap_flags.has_v ? hi_off(p_vhi, w_abs, w_p1) : BOX_W'(p_bhx);
    t_cand_nxt[S_HX][2] = e_fx_hi ? hi_off(p_fx, w_abs, w_p1) : BOX_W'(p_bhx);
    t_cand_nxt[S_HX][3] = e_tx_hi ? hi_off(p_t1x, w_abs, w_p1) : BOX_W'(p_bhx);

    t_cand_nxt[S_HY][0] = BOX_W'(p_bhy);
    t_cand_nxt[S_HY][1] = snap_flags.has_h ? hi_off(p_hhi, w_abs, w_p1) : BOX_W'(p_bhy);
    t_cand_nxt[S_HY][2] = e_fy_hi ? hi_off(p_fy, w_abs, w_p1) : BOX_W'(p_bhy);
    t_cand_nxt[S_HY][3] = e_ty_hi ? hi_off(p_t1y, w_abs, w_p1) : BOX_W'(p_bhy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_valid_r <= 1'b0;
    end else if (snap_ready) begin
      t_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      t_cand_r   <= t_cand_nxt;
      t_status_r <= snap_flags.status;
      t_count_r  <= snap_count;
      t_zero_r   <= (snap_flags.status != ST_OK) || w_zero;
    end
  end

  // Two-level min / max per side, zeroed on error or zero width
  always_comb begin
    out_blx_nxt = min2(min2($signed(t_cand_r[S_LX][0]), $signed(t_cand_r[S_LX][1])),
                       min2($signed(t_cand_r[S_LX][2]), $signed(t_cand_r[S_LX][3])));
    out_bly_nxt = min2(min2($signed(t_cand_r[S_LY][0]), $signed(t_cand_r[S_LY][1])),
                       min2($signed(t_cand_r[S_LY][2]), $signed(t_cand_r[S_LY][3])));
    out_bhx_nxt = max2(max2($signed(t_cand_r[S_HX][0]), $signed(t_cand_r[S_HX][1])),
                       max2($signed(t_cand_r[S_HX][2]), $signed(t_cand_r[S_HX][3])));
    out_bhy_nxt = max2(max2($signed(t_cand_r[S_HY][0]), $signed(t_cand_r[S_HY][1])),
                       max2($signed(t_cand_r[S_HY][2]), $signed(t_cand_r[S_HY][3])));
    if (t_zero_r) begin
      out_blx_nxt = '0;
      out_bly_nxt = '0;
      out_bhx_nxt = '0;
      out_bhy_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= t_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && t_valid_r) begin
      out_status_r <= t_status_r;
      out_count_r  <= t_count_r;
      out_blx_r    <= out_blx_nxt;
      out_bly_r    <= out_bly_nxt;
      out_bhx_r    <= out_bhx_nxt;
      out_bhy_r    <= out_bhy_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_box_low_x    = out_blx_r;
  assign out_box_low_y    = out_bly_r;
  assign out_box_high_x   = out_bhx_r;
  assign out_box_high_y   = out_bhy_r;
  assign out_vertex_count = out_count_r;

  // Error results carry an all-zero box
  a_err_zero_box: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |->
      (out_blx_r == '0) && (out_bly_r == '0) && (out_bhx_r == '0) && (out_bhy_r == '0))
    else $error("nonzero box on error status");

  // A diagonal path reports no vertices
  a_diag_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_DIAG)) |-> (out_count_r == '0))
    else $error("vertex count given with diagonal status");

  // A good box is never inverted
  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_OK)) |->
      (out_blx_r <= out_bhx_r) && (out_bly_r <= out_bhy_r))
    else $error("box low corner above high corner");

endmodule

`default_nettype wire
